// ===== rtl/psfe_pkg.sv =====
package psfe_pkg;

	localparam int MAX_SPHERES_DEF = 4;
	localparam int COORD_BITS_DEF  = 32;

	localparam int IDX_W   = 2;
	localparam int OP_W    = 2;
	localparam int POS_W   = 32;
	localparam int FORCE_W = 32;
	localparam int REST_W  = 32;
	localparam int CNT_W   = 3;
	localparam int DB_W    = 17;
	localparam int GAIN_W  = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int DIFF_W = 36;
	localparam int U_W    = 31;
	localparam int U_FRAC = 30;
	localparam int M_FRAC = 16;

	localparam int MUL_A_W   = 48;
	localparam int MUL_B_W   = 51;
	localparam int MUL_DIG   = 16;
	localparam int MUL_STEPS = MUL_A_W / MUL_DIG;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int FM_W      = MUL_P_W - U_FRAC;

	localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FORCE_GAIN   = 2'd2;

	localparam logic [CNT_W-1:0]  SPHERE_COUNT_RST = 3'd4;
	localparam logic [DB_W-1:0]   DEAD_BAND_RST    = 17'd6554;
	localparam logic [GAIN_W-1:0] FORCE_GAIN_RST   = 32'd65536;

	localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
	localparam logic [OP_W-1:0] OP_CAPTURE = 2'd1;
	localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

	typedef enum logic [1:0] {
		MS_SQ,
		MS_GAIN,
		MS_FORCE
	} msel_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PASS,
		ST_RD_C,
		ST_RD_R,
		ST_LOAD_D,
		ST_SQ_GO,
		ST_SQ_WAIT,
		ST_SQ_ACC,
		ST_RT_GO,
		ST_RT_WAIT,
		ST_RT_DONE,
		ST_CAP_WR,
		ST_EVAL,
		ST_GM_GO,
		ST_GM_WAIT,
		ST_GM_DONE,
		ST_AX_GO,
		ST_DV_WAIT,
		ST_U_LATCH,
		ST_FM_GO,
		ST_FM_WAIT,
		ST_F_LATCH,
		ST_EMIT_A,
		ST_EMIT_B,
		ST_ADVANCE,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [IDX_W-1:0] r;
		logic [IDX_W-1:0] c;
		logic [1:0]       axis;
		logic             load_centre;
		logic             rd_col;
		logic             latch_pc;
		logic             load_d;
		logic             mul_start;
		msel_t            mul_sel;
		logic             acc_sq;
		logic             rt_start;
		logic             div_start;
		logic             latch_len;
		logic             cap_wr;
		logic             latch_diff;
		logic             latch_m;
		logic             latch_u;
		logic             latch_f;
		logic             emit_a;
		logic             emit_b;
		logic             fin;
	} cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] n;
		logic             mul_busy;
		logic             rd_busy;
		logic             len_zero;
		logic             outside;
		logic             hold_v;
		logic             out_free;
	} sts_t;

	typedef struct packed {
		logic               force_valid;
		logic [IDX_W-1:0]   target_sphere;
		logic [IDX_W-1:0]   inducer_sphere;
		logic [FORCE_W-1:0] force_x;
		logic [FORCE_W-1:0] force_y;
		logic [FORCE_W-1:0] force_z;
		logic [POS_W-1:0]   base_x;
		logic [POS_W-1:0]   base_y;
		logic [POS_W-1:0]   base_z;
	} res_t;

	function automatic logic [FORCE_W-1:0] sat_force(logic neg, logic [FM_W-1:0] m);
		logic [FORCE_W-1:0] r;
		if (!neg) begin
			r = (m > FM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : m[FORCE_W-1:0];
		end else if (m > FM_W'(32'h8000_0000)) begin
			r = 32'h8000_0000;
		end else begin
			r = 32'd0 - m[FORCE_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/psfe_mul.sv =====
module psfe_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [psfe_pkg::MUL_A_W-1:0]  a,
	input  logic [psfe_pkg::MUL_B_W-1:0]  b,
	output logic [psfe_pkg::MUL_P_W-1:0]  prod,
	output logic                          busy
);

	localparam int AW  = psfe_pkg::MUL_A_W;
	localparam int BW  = psfe_pkg::MUL_B_W;
	localparam int PW  = psfe_pkg::MUL_P_W;
	localparam int DG  = psfe_pkg::MUL_DIG;
	localparam int PPW = DG + BW;
	localparam int SCW = $clog2(psfe_pkg::MUL_STEPS + 1);

	logic [SCW-1:0] cnt_q;
	logic [AW-1:0]  a_q;
	logic [BW-1:0]  b_q;
	logic [PW-1:0]  acc_q;
	logic [PPW-1:0] pp;

	assign pp   = PPW'(a_q[AW-1 -: DG]) * PPW'(b_q);
	assign busy = (cnt_q != '0);
	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= SCW'(psfe_pkg::MUL_STEPS);
		end else if (busy) begin
			cnt_q <= cnt_q - SCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy) begin
			a_q   <= a_q << DG;
			acc_q <= {acc_q[PW-1-DG:0], {DG{1'b0}}} + PW'(pp);
		end
	end

endmodule

// ===== rtl/psfe_rootdiv.sv =====
module psfe_rootdiv #(
	parameter int COORD_BITS = psfe_pkg::COORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start_root,
	input  logic                 start_div,
	input  logic [2*((COORD_BITS < 32 ? COORD_BITS : 32) + 1) + 1:0] rad,
	input  logic [(COORD_BITS < 32 ? COORD_BITS : 32):0]             dmag,
	input  logic [(COORD_BITS < 32 ? COORD_BITS : 32) + 1:0]         dvsr,
	output logic [((COORD_BITS < 32 ? COORD_BITS : 32) + 2 > psfe_pkg::U_W ?
		(COORD_BITS < 32 ? COORD_BITS : 32) + 2 : psfe_pkg::U_W) - 1:0] res,
	output logic                 busy
);

	localparam int CW   = (COORD_BITS < 32) ? COORD_BITS : 32;
	localparam int MW   = CW + 1;
	localparam int SW   = 2 * MW + 2;
	localparam int LW   = MW + 1;
	localparam int RMW  = LW + 2;
	localparam int QW   = (LW > psfe_pkg::U_W) ? LW : psfe_pkg::U_W;
	localparam int CNTW = $clog2(QW + 1);

	logic [CNTW-1:0] cnt_q;
	logic            root_q;
	logic [RMW-1:0]  rem_q;
	logic [SW-1:0]   src_q;
	logic [QW-1:0]   res_q;
	logic [LW-1:0]   dvsr_q;
	logic [RMW-1:0]  remsh;
	logic [RMW-1:0]  trial;
	logic            ge;

	always_comb begin
		if (root_q) begin
			remsh = {rem_q[RMW-3:0], src_q[SW-1 -: 2]};
			trial = {res_q[LW-1:0], 2'b01};
		end else begin
			remsh = {rem_q[RMW-2:0], src_q[SW-1]};
			trial = RMW'(dvsr_q);
		end
		ge = (remsh >= trial);
	end

	assign busy = (cnt_q != '0);
	assign res  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			root_q <= 1'b0;
		end else if (start_root) begin
			cnt_q  <= CNTW'(LW);
			root_q <= 1'b1;
		end else if (start_div) begin
			cnt_q  <= CNTW'(psfe_pkg::U_W);
			root_q <= 1'b0;
		end else if (busy) begin
			cnt_q <= cnt_q - CNTW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start_root) begin
			rem_q <= '0;
			src_q <= rad;
			res_q <= '0;
		end else if (start_div) begin
			rem_q  <= RMW'(dmag >> 1);
			src_q  <= {dmag[0], {(SW-1){1'b0}}};
			res_q  <= '0;
			dvsr_q <= dvsr;
		end else if (busy) begin
			rem_q <= ge ? (remsh - trial) : remsh;
			src_q <= root_q ? (src_q << 2) : (src_q << 1);
			res_q <= {res_q[QW-2:0], ge};
		end
	end

endmodule

// ===== rtl/psfe_dp.sv =====
module psfe_dp #(
	parameter int MAX_SPHERES = psfe_pkg::MAX_SPHERES_DEF,
	parameter int COORD_BITS  = psfe_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  psfe_pkg::cmd_t                      cmd,
	output psfe_pkg::sts_t                      sts,
	input  logic                                cfg_valid,
	input  logic [psfe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [psfe_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [psfe_pkg::IDX_W-1:0]          in_index,
	input  logic [psfe_pkg::POS_W-1:0]          in_x,
	input  logic [psfe_pkg::POS_W-1:0]          in_y,
	input  logic [psfe_pkg::POS_W-1:0]          in_z,
	input  logic                                m_tready,
	output psfe_pkg::res_t                      out_res,
	output logic                                out_last,
	output logic                                out_valid
);

	localparam int CW   = (COORD_BITS < 32) ? COORD_BITS : 32;
	localparam int MW   = CW + 1;
	localparam int DW   = CW + 1;
	localparam int SW   = 2 * MW + 2;
	localparam int LW   = MW + 1;
	localparam int QW   = (LW > psfe_pkg::U_W) ? LW : psfe_pkg::U_W;
	localparam int IW   = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
	localparam int RDEP = MAX_SPHERES * MAX_SPHERES;
	localparam int RIW  = $clog2(RDEP);
	localparam int NMAX = (MAX_SPHERES < 4) ? MAX_SPHERES : 4;
	localparam int DFW  = psfe_pkg::DIFF_W;
	localparam int PW   = psfe_pkg::MUL_P_W;

	logic [psfe_pkg::CNT_W-1:0]  sphere_count_q;
	logic [psfe_pkg::DB_W-1:0]   dead_band_q;
	logic [psfe_pkg::GAIN_W-1:0] force_gain_q;

	logic signed [CW-1:0] cen_mem [3][MAX_SPHERES];
	logic [psfe_pkg::REST_W-1:0] rest_mem [RDEP];
	logic [psfe_pkg::POS_W-1:0] in_pos [3];

	logic signed [CW-1:0] rd_q [3];
	logic signed [CW-1:0] pc_q [3];
	logic signed [CW-1:0] pr_q [3];
	logic signed [DW-1:0] d_q [3];
	logic [MW-1:0]        dmag [3];
	logic [psfe_pkg::REST_W-1:0] rest_rd_q;
	logic [SW-1:0]        s_q;
	logic [LW-1:0]        len_q;
	logic [DFW-2:0]       diffmag_q;
	logic                 diffneg_q;
	logic [psfe_pkg::MUL_B_W-1:0] m_q;
	logic [psfe_pkg::U_W-1:0]     u_q;
	logic [psfe_pkg::FORCE_W-1:0] fa_q [3];
	logic [psfe_pkg::FORCE_W-1:0] fb_q [3];

	logic [IW-1:0]  rd_addr;
	logic [RIW-1:0] ridx;
	logic [63:0]    len64;
	logic [psfe_pkg::REST_W-1:0] rest_val;
	logic [DFW-1:0] diff;
	logic [DFW-1:0] diff_abs;
	logic           fneg;
	logic [psfe_pkg::FM_W-1:0] fm;

	logic [psfe_pkg::MUL_A_W-1:0] mul_a;
	logic [psfe_pkg::MUL_B_W-1:0] mul_b;
	logic [PW-1:0]  prod;
	logic           mul_busy;
	logic [QW-1:0]  rd_res;
	logic           rd_busy;

	psfe_pkg::res_t hold_q;
	logic           hold_v_q;
	psfe_pkg::res_t out_q;
	logic           out_last_q;
	logic           out_v_q;
	psfe_pkg::res_t res_a;
	psfe_pkg::res_t res_b;
	logic           out_free;

	assign in_pos[0] = in_x;
	assign in_pos[1] = in_y;
	assign in_pos[2] = in_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sphere_count_q <= psfe_pkg::SPHERE_COUNT_RST;
			dead_band_q    <= psfe_pkg::DEAD_BAND_RST;
			force_gain_q   <= psfe_pkg::FORCE_GAIN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				psfe_pkg::CFG_SPHERE_COUNT: sphere_count_q <= cfg_data[psfe_pkg::CNT_W-1:0];
				psfe_pkg::CFG_DEAD_BAND:    dead_band_q    <= cfg_data[psfe_pkg::DB_W-1:0];
				psfe_pkg::CFG_FORCE_GAIN:   force_gain_q   <= cfg_data[psfe_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign rd_addr = cmd.rd_col ? IW'(cmd.c) : IW'(cmd.r);
	assign ridx    = RIW'(32'(cmd.r) * MAX_SPHERES + 32'(cmd.c));

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (cmd.load_centre && (32'(in_index) < MAX_SPHERES)) begin
				cen_mem[i][IW'(in_index)] <= in_pos[i][CW-1:0];
			end
			rd_q[i] <= cen_mem[i][rd_addr];
		end
	end

	assign len64    = 64'(len_q);
	assign rest_val = (len64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len64[31:0];

	always_ff @(posedge clk) begin
		if (cmd.cap_wr) begin
			rest_mem[ridx] <= rest_val;
		end
		rest_rd_q <= rest_mem[ridx];
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dmag[i] = d_q[i][DW-1] ? MW'(-d_q[i]) : MW'(d_q[i]);
		end
		diff     = DFW'(len_q) - DFW'(rest_rd_q);
		diff_abs = diff[DFW-1] ? (DFW'(0) - diff) : diff;
		fneg     = d_q[cmd.axis][DW-1] ^ diffneg_q;
		fm       = prod[PW-1:psfe_pkg::U_FRAC];
	end

	always_comb begin
		case (cmd.mul_sel)
			psfe_pkg::MS_SQ: begin
				mul_a = psfe_pkg::MUL_A_W'(dmag[cmd.axis]);
				mul_b = psfe_pkg::MUL_B_W'(dmag[cmd.axis]);
			end
			psfe_pkg::MS_GAIN: begin
				mul_a = psfe_pkg::MUL_A_W'(diffmag_q);
				mul_b = psfe_pkg::MUL_B_W'(force_gain_q);
			end
			psfe_pkg::MS_FORCE: begin
				mul_a = psfe_pkg::MUL_A_W'(u_q);
				mul_b = m_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	psfe_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (prod),
		.busy   (mul_busy)
	);

	psfe_rootdiv #(
		.COORD_BITS (COORD_BITS)
	) u_rootdiv (
		.clk        (clk),
		.arst_n     (arst_n),
		.start_root (cmd.rt_start),
		.start_div  (cmd.div_start),
		.rad        (s_q),
		.dmag       (dmag[cmd.axis]),
		.dvsr       (len_q),
		.res        (rd_res),
		.busy       (rd_busy)
	);

	always_ff @(posedge clk) begin
		if (cmd.latch_pc) begin
			pc_q <= rd_q;
		end
		if (cmd.load_d) begin
			pr_q <= rd_q;
			for (int i = 0; i < 3; i++) begin
				d_q[i] <= DW'(pc_q[i]) - DW'(rd_q[i]);
			end
			s_q <= '0;
		end
		if (cmd.acc_sq) begin
			s_q <= s_q + SW'(prod);
		end
		if (cmd.latch_len) begin
			len_q <= rd_res[LW-1:0];
		end
		if (cmd.latch_diff) begin
			diffmag_q <= diff_abs[DFW-2:0];
			diffneg_q <= diff[DFW-1];
		end
		if (cmd.latch_m) begin
			m_q <= prod[psfe_pkg::M_FRAC +: psfe_pkg::MUL_B_W];
		end
		if (cmd.latch_u) begin
			u_q <= (len_q == '0) ? '0 : rd_res[psfe_pkg::U_W-1:0];
		end
		if (cmd.latch_f) begin
			fa_q[cmd.axis] <= psfe_pkg::sat_force(fneg, fm);
			fb_q[cmd.axis] <= psfe_pkg::sat_force(!fneg, fm);
		end
	end

	always_comb begin
		res_a.force_valid    = 1'b1;
		res_a.target_sphere  = cmd.r;
		res_a.inducer_sphere = cmd.c;
		res_a.force_x        = fa_q[0];
		res_a.force_y        = fa_q[1];
		res_a.force_z        = fa_q[2];
		res_a.base_x         = psfe_pkg::POS_W'(pr_q[0]);
		res_a.base_y         = psfe_pkg::POS_W'(pr_q[1]);
		res_a.base_z         = psfe_pkg::POS_W'(pr_q[2]);
		res_b.force_valid    = 1'b1;
		res_b.target_sphere  = cmd.c;
		res_b.inducer_sphere = cmd.r;
		res_b.force_x        = fb_q[0];
		res_b.force_y        = fb_q[1];
		res_b.force_z        = fb_q[2];
		res_b.base_x         = psfe_pkg::POS_W'(pc_q[0]);
		res_b.base_y         = psfe_pkg::POS_W'(pc_q[1]);
		res_b.base_z         = psfe_pkg::POS_W'(pc_q[2]);
	end

	assign out_free = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_v_q && m_tready) begin
				out_v_q <= 1'b0;
			end
			if (cmd.emit_a || cmd.emit_b) begin
				if (hold_v_q) begin
					out_v_q <= 1'b1;
				end
				hold_v_q <= 1'b1;
			end else if (cmd.fin) begin
				out_v_q  <= 1'b1;
				hold_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_a || cmd.emit_b) begin
			if (hold_v_q) begin
				out_q      <= hold_q;
				out_last_q <= 1'b0;
			end
			hold_q <= cmd.emit_a ? res_a : res_b;
		end else if (cmd.fin) begin
			out_q      <= hold_v_q ? hold_q : '0;
			out_last_q <= 1'b1;
		end
	end

	assign out_res   = out_q;
	assign out_last  = out_last_q;
	assign out_valid = out_v_q;

	always_comb begin
		sts.n        = (32'(sphere_count_q) > NMAX) ? psfe_pkg::CNT_W'(NMAX) : sphere_count_q;
		sts.mul_busy = mul_busy;
		sts.rd_busy  = rd_busy;
		sts.len_zero = (len_q == '0);
		sts.outside  = (diff_abs > DFW'(dead_band_q));
		sts.hold_v   = hold_v_q;
		sts.out_free = out_free;
	end

endmodule

// ===== rtl/psfe_ctrl.sv =====
module psfe_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [psfe_pkg::OP_W-1:0]   opcode,
	input  psfe_pkg::sts_t              sts,
	output psfe_pkg::cmd_t              cmd
);

	localparam int NW = psfe_pkg::CNT_W;

	psfe_pkg::state_t state_q;
	psfe_pkg::state_t state_d;
	logic                       mode_q;
	logic [psfe_pkg::IDX_W-1:0] r_q;
	logic [psfe_pkg::IDX_W-1:0] c_q;
	logic [1:0]                 axis_q;
	logic                       start_pass;
	logic                       c_more;
	logic                       r_more;
	logic                       emit_ok;

	assign start_pass = (state_q == psfe_pkg::ST_IDLE) && s_tvalid &&
		((opcode == psfe_pkg::OP_CAPTURE) || (opcode == psfe_pkg::OP_COMPUTE));
	assign c_more  = (NW'(c_q) + NW'(1)) < sts.n;
	assign r_more  = (NW'(r_q) + NW'(2)) < sts.n;
	assign emit_ok = !sts.hold_v || sts.out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			psfe_pkg::ST_IDLE:    if (start_pass) state_d = psfe_pkg::ST_PASS;
			psfe_pkg::ST_PASS: begin
				if (sts.n < NW'(2)) begin
					state_d = mode_q ? psfe_pkg::ST_FIN : psfe_pkg::ST_IDLE;
				end else begin
					state_d = psfe_pkg::ST_RD_C;
				end
			end
			psfe_pkg::ST_RD_C:    state_d = psfe_pkg::ST_RD_R;
			psfe_pkg::ST_RD_R:    state_d = psfe_pkg::ST_LOAD_D;
			psfe_pkg::ST_LOAD_D:  state_d = psfe_pkg::ST_SQ_GO;
			psfe_pkg::ST_SQ_GO:   state_d = psfe_pkg::ST_SQ_WAIT;
			psfe_pkg::ST_SQ_WAIT: if (!sts.mul_busy) state_d = psfe_pkg::ST_SQ_ACC;
			psfe_pkg::ST_SQ_ACC: begin
				state_d = (axis_q == 2'd2) ? psfe_pkg::ST_RT_GO : psfe_pkg::ST_SQ_GO;
			end
			psfe_pkg::ST_RT_GO:   state_d = psfe_pkg::ST_RT_WAIT;
			psfe_pkg::ST_RT_WAIT: if (!sts.rd_busy) state_d = psfe_pkg::ST_RT_DONE;
			psfe_pkg::ST_RT_DONE: state_d = mode_q ? psfe_pkg::ST_EVAL : psfe_pkg::ST_CAP_WR;
			psfe_pkg::ST_CAP_WR:  state_d = psfe_pkg::ST_ADVANCE;
			psfe_pkg::ST_EVAL: begin
				state_d = sts.outside ? psfe_pkg::ST_GM_GO : psfe_pkg::ST_ADVANCE;
			end
			psfe_pkg::ST_GM_GO:   state_d = psfe_pkg::ST_GM_WAIT;
			psfe_pkg::ST_GM_WAIT: if (!sts.mul_busy) state_d = psfe_pkg::ST_GM_DONE;
			psfe_pkg::ST_GM_DONE: state_d = psfe_pkg::ST_AX_GO;
			psfe_pkg::ST_AX_GO: begin
				state_d = sts.len_zero ? psfe_pkg::ST_U_LATCH : psfe_pkg::ST_DV_WAIT;
			end
			psfe_pkg::ST_DV_WAIT: if (!sts.rd_busy) state_d = psfe_pkg::ST_U_LATCH;
			psfe_pkg::ST_U_LATCH: state_d = psfe_pkg::ST_FM_GO;
			psfe_pkg::ST_FM_GO:   state_d = psfe_pkg::ST_FM_WAIT;
			psfe_pkg::ST_FM_WAIT: if (!sts.mul_busy) state_d = psfe_pkg::ST_F_LATCH;
			psfe_pkg::ST_F_LATCH: begin
				state_d = (axis_q == 2'd2) ? psfe_pkg::ST_EMIT_A : psfe_pkg::ST_AX_GO;
			end
			psfe_pkg::ST_EMIT_A:  if (emit_ok) state_d = psfe_pkg::ST_EMIT_B;
			psfe_pkg::ST_EMIT_B:  if (emit_ok) state_d = psfe_pkg::ST_ADVANCE;
			psfe_pkg::ST_ADVANCE: begin
				if (c_more || r_more) begin
					state_d = psfe_pkg::ST_RD_C;
				end else begin
					state_d = mode_q ? psfe_pkg::ST_FIN : psfe_pkg::ST_IDLE;
				end
			end
			psfe_pkg::ST_FIN:     if (sts.out_free) state_d = psfe_pkg::ST_IDLE;
			default:              state_d = psfe_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd             = '0;
		cmd.r           = r_q;
		cmd.c           = c_q;
		cmd.axis        = axis_q;
		cmd.mul_sel     = psfe_pkg::MS_SQ;
		s_tready        = (state_q == psfe_pkg::ST_IDLE);
		cmd.load_centre = s_tready && s_tvalid && (opcode == psfe_pkg::OP_LOAD);
		unique case (state_q)
			psfe_pkg::ST_RD_C:    cmd.rd_col = 1'b1;
			psfe_pkg::ST_RD_R:    cmd.latch_pc = 1'b1;
			psfe_pkg::ST_LOAD_D:  cmd.load_d = 1'b1;
			psfe_pkg::ST_SQ_GO:   cmd.mul_start = 1'b1;
			psfe_pkg::ST_SQ_ACC:  cmd.acc_sq = 1'b1;
			psfe_pkg::ST_RT_GO:   cmd.rt_start = 1'b1;
			psfe_pkg::ST_RT_DONE: cmd.latch_len = 1'b1;
			psfe_pkg::ST_CAP_WR:  cmd.cap_wr = 1'b1;
			psfe_pkg::ST_EVAL:    cmd.latch_diff = 1'b1;
			psfe_pkg::ST_GM_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = psfe_pkg::MS_GAIN;
			end
			psfe_pkg::ST_GM_DONE: cmd.latch_m = 1'b1;
			psfe_pkg::ST_AX_GO:   cmd.div_start = !sts.len_zero;
			psfe_pkg::ST_U_LATCH: cmd.latch_u = 1'b1;
			psfe_pkg::ST_FM_GO: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = psfe_pkg::MS_FORCE;
			end
			psfe_pkg::ST_F_LATCH: cmd.latch_f = 1'b1;
			psfe_pkg::ST_EMIT_A:  cmd.emit_a = emit_ok;
			psfe_pkg::ST_EMIT_B:  cmd.emit_b = emit_ok;
			psfe_pkg::ST_FIN:     cmd.fin = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psfe_pkg::ST_IDLE;
			mode_q  <= 1'b0;
			r_q     <= '0;
			c_q     <= '0;
			axis_q  <= '0;
		end else begin
			state_q <= state_d;
			if (start_pass) begin
				mode_q <= (opcode == psfe_pkg::OP_COMPUTE);
				r_q    <= '0;
				c_q    <= psfe_pkg::IDX_W'(1);
			end
			if ((state_q == psfe_pkg::ST_LOAD_D) || (state_q == psfe_pkg::ST_GM_DONE)) begin
				axis_q <= '0;
			end
			if ((state_q == psfe_pkg::ST_SQ_ACC) || (state_q == psfe_pkg::ST_F_LATCH)) begin
				axis_q <= axis_q + 2'd1;
			end
			if (state_q == psfe_pkg::ST_ADVANCE) begin
				if (c_more) begin
					c_q <= c_q + psfe_pkg::IDX_W'(1);
				end else if (r_more) begin
					r_q <= r_q + psfe_pkg::IDX_W'(1);
					c_q <= r_q + psfe_pkg::IDX_W'(2);
				end
			end
		end
	end

endmodule

// ===== rtl/pairwise_spring_force_engine_unit.sv =====
// A centre load is taken while the block is idle, and the block stays ready for the next item.
// A rest capture runs a bit-serial square root per sphere pair; a force pass also runs up to
// three divisions per pair, and the root and the divisions share one shift-subtract unit;
// passes run one at a time.
// Reset is asynchronous and active low: control and configuration registers take their
// reset values, while the centre and rest distance stores hold nothing until written.
module pairwise_spring_force_engine_unit #(
	parameter int MAX_SPHERES = psfe_pkg::MAX_SPHERES_DEF,
	parameter int COORD_BITS  = psfe_pkg::COORD_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// sphere_index[1:0], pos_x[33:2], pos_y[65:34], pos_z[97:66], zero fill.
	input  logic [103:0] s_tdata,
	// opcode[1:0].
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// target_sphere[1:0], inducer_sphere[3:2], force_x[35:4], force_y[67:36],
	// force_z[99:68], base_x[131:100], base_y[163:132], base_z[195:164], zero fill.
	output logic [199:0] m_tdata,
	// force_valid[0].
	output logic [0:0]   m_tuser,
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	psfe_pkg::cmd_t cmd;
	psfe_pkg::sts_t sts;
	psfe_pkg::res_t res;

	assign cfg_ready = 1'b1;

	psfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.opcode   (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	psfe_dp #(
		.MAX_SPHERES (MAX_SPHERES),
		.COORD_BITS  (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_index  (s_tdata[1:0]),
		.in_x      (s_tdata[33:2]),
		.in_y      (s_tdata[65:34]),
		.in_z      (s_tdata[97:66]),
		.m_tready  (m_tready),
		.out_res   (res),
		.out_last  (m_tlast),
		.out_valid (m_tvalid)
	);

	assign m_tdata = {4'b0, res.base_z, res.base_y, res.base_x, res.force_z, res.force_y,
		res.force_x, res.inducer_sphere, res.target_sphere};
	assign m_tuser = res.force_valid;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

	localparam logic [psfe_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 30000;
	localparam int DRAIN_CYCLES = 1500;

	typedef struct {
		logic        fv;
		logic [1:0]  tgt;
		logic [1:0]  ind;
		logic [31:0] fx, fy, fz, bx, by, bz;
		logic        lst;
	} force_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [103:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [199:0] m_tdata;
	logic [0:0] m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	force_rec_t force_q[$];
	int errors = 0;
	int idle_cnt = 0;
	int hold_cycles = 0;
	bit quiet = 1'b0;

	logic signed [31:0] cx[4], cy[4], cz[4];
	logic [31:0] rest_len[16];
	logic [2:0] n_cfg = psfe_pkg::SPHERE_COUNT_RST;
	logic [16:0] band_cfg = psfe_pkg::DEAD_BAND_RST;
	logic [31:0] gain_cfg = psfe_pkg::FORCE_GAIN_RST;

	pairwise_spring_force_engine_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic logic [127:0] mag(longint v);
		return v < 0 ? 128'(-v) : 128'(v);
	endfunction

	function automatic logic [63:0] root_of(logic [127:0] s);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = 40; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if ({64'd0, t} * {64'd0, t} <= s) r = t;
		end
		return r;
	endfunction

	function automatic logic [63:0] pair_len(int r, int c, output longint d[3]);
		logic [127:0] s;
		d[0] = longint'(cx[c]) - longint'(cx[r]);
		d[1] = longint'(cy[c]) - longint'(cy[r]);
		d[2] = longint'(cz[c]) - longint'(cz[r]);
		s = mag(d[0]) * mag(d[0]) + mag(d[1]) * mag(d[1]) + mag(d[2]) * mag(d[2]);
		return root_of(s);
	endfunction

	function automatic logic [31:0] clip(bit neg, logic [127:0] m);
		if (!neg) return m > 128'h7FFF_FFFF ? 32'h7FFF_FFFF : m[31:0];
		if (m > 128'h8000_0000) m = 128'h8000_0000;
		return 32'd0 - m[31:0];
	endfunction

	task automatic push_force(int tgt, int ind, logic [31:0] f[3]);
		force_rec_t e;
		e.fv = 1'b1; e.tgt = tgt[1:0]; e.ind = ind[1:0];
		e.fx = f[0]; e.fy = f[1]; e.fz = f[2];
		e.bx = cx[tgt]; e.by = cy[tgt]; e.bz = cz[tgt];
		e.lst = 1'b0;
		force_q.insert(force_q.size(), e);
	endtask

	task automatic apply_op(logic [1:0] op, logic [1:0] idx, logic [31:0] x, y, z);
		int n, cnt;
		longint d[3], diff, db;
		logic [63:0] len;
		logic [127:0] m, u, fm;
		logic [31:0] fa[3], fb[3];
		force_rec_t e;
		bit neg;
		n = n_cfg > 4 ? 4 : n_cfg;
		cnt = 0;
		if (op == psfe_pkg::OP_LOAD) begin
			cx[idx] = x; cy[idx] = y; cz[idx] = z;
		end else if (op == psfe_pkg::OP_CAPTURE) begin
			for (int r = 0; r < n; r++)
				for (int c = r + 1; c < n; c++) begin
					len = pair_len(r, c, d);
					if (len > 64'hFFFF_FFFF) len = 64'hFFFF_FFFF;
					rest_len[r*4+c] = len[31:0];
					rest_len[c*4+r] = len[31:0];
				end
		end else if (op == psfe_pkg::OP_COMPUTE) begin
			for (int r = 0; r < n; r++)
				for (int c = r + 1; c < n; c++) begin
					len = pair_len(r, c, d);
					diff = longint'(len) - longint'({32'd0, rest_len[r*4+c]});
					db = longint'({47'd0, band_cfg});
					if (diff > db || diff < -db) begin
						m = (mag(diff) * {96'd0, gain_cfg}) >> 16;
						for (int i = 0; i < 3; i++) begin
							u = len != 0 ? (mag(d[i]) << 30) / {64'd0, len} : '0;
							fm = (u * m) >> 30;
							neg = (d[i] < 0) != (diff < 0);
							fa[i] = clip(neg, fm);
							fb[i] = clip(!neg, fm);
						end
						push_force(r, c, fa);
						push_force(c, r, fb);
						cnt += 2;
					end
				end
			if (cnt == 0) begin
				e = '{default: '0};
				e.lst = 1'b1;
				force_q.insert(force_q.size(), e);
			end else begin
				force_q[$].lst = 1'b1;
			end
		end
	endtask

	task automatic send_item(logic [1:0] op, logic [1:0] idx, logic [31:0] x, y, z);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'd0, z, y, x, idx};
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		apply_op(op, idx, x, y, z);
		if (!quiet && $urandom_range(0, 99) < 21) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (force_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		if (idx == psfe_pkg::CFG_SPHERE_COUNT) n_cfg = val[2:0];
		else if (idx == psfe_pkg::CFG_DEAD_BAND) band_cfg = val[16:0];
		else if (idx == psfe_pkg::CFG_FORCE_GAIN) gain_cfg = val;
	endtask

	task automatic configure(logic [31:0] n, band, gain);
		drain();
		write_reg(psfe_pkg::CFG_SPHERE_COUNT, n);
		write_reg(psfe_pkg::CFG_DEAD_BAND, band);
		write_reg(psfe_pkg::CFG_FORCE_GAIN, gain);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] nudge(logic [31:0] v);
		int span;
		case ($urandom_range(0, 2))
			0: span = 100;
			1: span = 8000;
			default: span = 200000;
		endcase
		return v + $urandom_range(0, 2 * span) - span;
	endfunction

	function automatic logic [31:0] any_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
		endcase
	endfunction

	task automatic move_sphere(logic [1:0] s);
		int k;
		k = $urandom_range(0, 99);
		if (k < 10) begin
			send_item(psfe_pkg::OP_LOAD, s, any_coord(), any_coord(), any_coord());
		end else if (k < 15) begin
			k = $urandom_range(0, 3);
			send_item(psfe_pkg::OP_LOAD, s, cx[k], cy[k], cz[k]);
		end else begin
			send_item(psfe_pkg::OP_LOAD, s, nudge(cx[s]), nudge(cy[s]), nudge(cz[s]));
		end
	endtask

	task automatic test_setup();
		send_item(psfe_pkg::OP_LOAD, 2'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_item(psfe_pkg::OP_LOAD, 2'd1, 32'h0003_0000, 32'h0000_0000, 32'h0000_0000);
		send_item(psfe_pkg::OP_LOAD, 2'd2, 32'h0000_0000, 32'hFFFC_0000, 32'h0000_0000);
		send_item(psfe_pkg::OP_LOAD, 2'd3, 32'h0001_8000, 32'h0001_0000, 32'h0002_0000);
		send_item(psfe_pkg::OP_CAPTURE, 2'd0, '0, '0, '0);
		send_item(psfe_pkg::OP_COMPUTE, 2'd0, '0, '0, '0);
	endtask

	task automatic test_extremes();
		send_item(psfe_pkg::OP_LOAD, 2'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_item(psfe_pkg::OP_LOAD, 2'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_item(psfe_pkg::OP_CAPTURE, 2'd0, '0, '0, '0);
		send_item(psfe_pkg::OP_LOAD, 2'd1, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
		send_item(OP_UNUSED, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(psfe_pkg::OP_COMPUTE, 2'd1, '0, '0, '0);
	endtask

	task automatic test_zero_length();
		send_item(psfe_pkg::OP_LOAD, 2'd2, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000);
		send_item(psfe_pkg::OP_CAPTURE, 2'd0, '0, '0, '0);
		send_item(psfe_pkg::OP_LOAD, 2'd2, cx[3], cy[3], cz[3]);
		send_item(psfe_pkg::OP_COMPUTE, 2'd0, '0, '0, '0);
	endtask

	task automatic test_empty_pass();
		send_item(psfe_pkg::OP_CAPTURE, 2'd0, '0, '0, '0);
		send_item(psfe_pkg::OP_COMPUTE, 2'd2, '0, '0, '0);
		send_item(OP_UNUSED, 2'd0, '0, '0, '0);
		send_item(psfe_pkg::OP_COMPUTE, 2'd3, '0, '0, '0);
	endtask

	task automatic test_random(int items);
		int sent;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(0, 99) < 12) begin
				send_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), $urandom,
					$urandom, $urandom);
				sent++;
			end else begin
				repeat ($urandom_range(1, 3)) begin
					move_sphere(2'($urandom_range(0, 3)));
					sent++;
				end
				if ($urandom_range(0, 99) < 30) begin
					send_item(psfe_pkg::OP_CAPTURE, 2'($urandom_range(0, 3)), $urandom,
						$urandom, $urandom);
					sent++;
				end
				send_item(psfe_pkg::OP_COMPUTE, 2'($urandom_range(0, 3)), $urandom, $urandom,
					$urandom);
				sent++;
			end
		end
	endtask

	task automatic test_backpressure();
		hold_cycles = 4000;
		repeat (5) begin
			move_sphere(2'($urandom_range(0, 3)));
			send_item(psfe_pkg::OP_COMPUTE, 2'd0, '0, '0, '0);
		end
		s_tvalid <= 1'b0;
		while (force_q.size() != 0) @(posedge clk);
		send_item(psfe_pkg::OP_COMPUTE, 2'd0, '0, '0, '0);
	endtask

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (quiet) begin
			m_tready <= 1'b1;
		end else if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= $urandom_range(0, 99) >= 21;
		end
	end

	always @(negedge clk) begin
		force_rec_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (force_q.size() == 0) begin
				$error("result with nothing expected: %h", m_tdata);
				errors++;
			end else begin
				e = force_q.pop_front();
				check_field("force_valid", 32'(e.fv), 32'(m_tuser[0]));
				check_field("target_sphere", 32'(e.tgt), 32'(m_tdata[1:0]));
				check_field("inducer_sphere", 32'(e.ind), 32'(m_tdata[3:2]));
				check_field("force_x", e.fx, m_tdata[35:4]);
				check_field("force_y", e.fy, m_tdata[67:36]);
				check_field("force_z", e.fz, m_tdata[99:68]);
				check_field("base_x", e.bx, m_tdata[131:100]);
				check_field("base_y", e.by, m_tdata[163:132]);
				check_field("base_z", e.bz, m_tdata[195:164]);
				check_field("last", 32'(e.lst), 32'(m_tlast));
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cnt = 0;
			else
				idle_cnt++;
			if (idle_cnt >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_setup();
		test_extremes();
		test_zero_length();
		test_empty_pass();
		configure(4, 6554, 65536);
		quiet = 1'b1;
		test_random(70);
		configure(2, 0, 0);
		quiet = 1'b0;
		test_random(60);
		configure(3, 65536, 32'hFFFF_FFFF);
		test_random(70);
		configure(4, 0, 32'hFFFF_FFFF);
		test_random(70);
		configure(1, 300, 32'h0001_8000);
		test_random(30);
		configure($urandom_range(0, 7), $urandom_range(0, 65536), $urandom);
		test_random(80);
		configure(4, $urandom_range(0, 20000), $urandom_range(0, 32'h0004_0000));
		test_random(60);
		test_backpressure();
		drain();
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/psfe_pkg.sv
rtl/psfe_mul.sv
rtl/psfe_rootdiv.sv
rtl/psfe_dp.sv
rtl/psfe_ctrl.sv
rtl/pairwise_spring_force_engine_unit.sv
tb/tb.sv
